// File: rtl/ecc_pkg.sv
// ----------------------------------------------------------------------------
// Epoch calendar converter package
// Shared types, constants and calendar helper functions.
// ----------------------------------------------------------------------------
package ecc_pkg;

   localparam logic [2:0] CMD_TO_UTC      = 3'd0;
   localparam logic [2:0] CMD_TO_LOCAL    = 3'd1;
   localparam logic [2:0] CMD_TO_RTC      = 3'd2;
   localparam logic [2:0] CMD_TO_SECS     = 3'd3;
   localparam logic [2:0] CMD_RTC_TO_SECS = 3'd4;

   localparam logic [1:0] REG_TZ_OFFSET  = 2'd0;
   localparam logic [1:0] REG_DAYLIGHT   = 2'd1;
   localparam logic [1:0] REG_RTC_OFFSET = 2'd2;

   localparam logic signed [10:0] TZ_MIN     = -11'sd720;
   localparam logic signed [10:0] TZ_MAX     = 11'sd840;
   localparam logic [16:0]        RTC_MAX    = 17'd86399;
   localparam logic [16:0]        RTC_RESET  = 17'd32400;
   localparam logic signed [17:0] DST_SECS   = 18'sd3600;

   localparam logic [11:0] YEAR_FIRST   = 12'd1970;
   localparam logic [11:0] YEAR_LAST    = 12'd2100;
   localparam logic [11:0] YEAR_CENTURY = 12'd2100;

   localparam logic [31:0] SECS_YEAR      = 32'd31536000;
   localparam logic [31:0] SECS_LEAP_YEAR = 32'd31622400;
   localparam logic [31:0] SECS_MONTH_31  = 32'd2678400;
   localparam logic [31:0] SECS_MONTH_30  = 32'd2592000;
   localparam logic [31:0] SECS_MONTH_29  = 32'd2505600;
   localparam logic [31:0] SECS_MONTH_28  = 32'd2419200;
   localparam logic [31:0] SECS_DAY       = 32'd86400;
   localparam logic [31:0] SECS_HOUR      = 32'd3600;
   localparam logic [31:0] SECS_MINUTE    = 32'd60;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_OFFSET,
      ST_YEAR,
      ST_MONTH,
      ST_DAY,
      ST_HOUR,
      ST_MINUTE,
      ST_ADD_YEAR,
      ST_ADD_MONTH,
      ST_ADD_DAY,
      ST_ADD_HOUR,
      ST_ADD_MINUTE,
      ST_ADD_SECOND,
      ST_SUB_RTC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [10:0] tz_offset_minutes;
      logic               daylight_saving;
      logic [16:0]        rtc_offset_seconds;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      tz_offset_minutes:  11'sd0,
      daylight_saving:    1'b0,
      rtc_offset_seconds: RTC_RESET
   };

   typedef struct packed {
      logic        status;
      logic [31:0] epoch_out;
      logic [11:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [4:0]  out_hour;
      logic [5:0]  out_minute;
      logic [5:0]  out_second;
   } result_type;

   // Only the century year 2100 breaks the four-year rule between 1970 and 2106.
   function automatic logic is_leap(input logic [11:0] y);
      return (y[1:0] == 2'b00) && (y != YEAR_CENTURY);
   endfunction

   function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m);
      logic [4:0] n;
      case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
         4'd2:    n = is_leap(y) ? 5'd29 : 5'd28;
         default: n = 5'd0;
      endcase
      return n;
   endfunction

   function automatic logic [31:0] month_secs(input logic [11:0] y, input logic [3:0] m);
      logic [31:0] s;
      case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: s = SECS_MONTH_31;
         4'd4, 4'd6, 4'd9, 4'd11:                    s = SECS_MONTH_30;
         4'd2:    s = is_leap(y) ? SECS_MONTH_29 : SECS_MONTH_28;
         default: s = 32'd0;
      endcase
      return s;
   endfunction

   function automatic logic [31:0] year_secs(input logic [11:0] y);
      return is_leap(y) ? SECS_LEAP_YEAR : SECS_YEAR;
   endfunction

endpackage

// File: rtl/ecc_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one conversion request word.
// ----------------------------------------------------------------------------
interface ecc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [31:0] epoch_in;
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;

   modport source (
      output valid, cmd, epoch_in, year, month, day, hour, minute, second,
      input  ready
   );
   modport sink (
      input  valid, cmd, epoch_in, year, month, day, hour, minute, second,
      output ready
   );
endinterface

// File: rtl/ecc_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one conversion result word.
// ----------------------------------------------------------------------------
interface ecc_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] epoch_out;
   logic [11:0] out_year;
   logic [3:0]  out_month;
   logic [4:0]  out_day;
   logic [4:0]  out_hour;
   logic [5:0]  out_minute;
   logic [5:0]  out_second;

   modport source (
      output valid, status, epoch_out, out_year, out_month, out_day, out_hour,
             out_minute, out_second,
      input  ready
   );
   modport sink (
      input  valid, status, epoch_out, out_year, out_month, out_day, out_hour,
             out_minute, out_second,
      output ready
   );
endinterface

// File: rtl/ecc_csr_if.sv
// ----------------------------------------------------------------------------
// Register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ecc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [16:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/ecc_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the timezone, daylight saving and hardware clock offsets.
// ----------------------------------------------------------------------------
module ecc_cfg (
   input  logic            clock,
   input  logic            reset,
   ecc_csr_if.sink         csr_chan,
   output ecc_pkg::cfg_type cfg
);

   ecc_pkg::cfg_type   cfg_ff;
   ecc_pkg::cfg_type   cfg_in;
   logic signed [10:0] tz_value;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in   = cfg_ff;
      tz_value = signed'(csr_chan.data[10:0]);
      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            ecc_pkg::REG_TZ_OFFSET: begin
               if (tz_value >= ecc_pkg::TZ_MIN && tz_value <= ecc_pkg::TZ_MAX) begin
                  cfg_in.tz_offset_minutes = tz_value;
               end
            end
            ecc_pkg::REG_DAYLIGHT: begin
               cfg_in.daylight_saving = csr_chan.data[0];
            end
            ecc_pkg::REG_RTC_OFFSET: begin
               if (csr_chan.data <= ecc_pkg::RTC_MAX) begin
                  cfg_in.rtc_offset_seconds = csr_chan.data;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ecc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/ecc_alu.sv
// ----------------------------------------------------------------------------
// Shared adder
// One 32-bit add or subtract with carry or borrow out, used by every step.
// ----------------------------------------------------------------------------
module ecc_alu (
   input  logic [31:0] acc,
   input  logic [31:0] operand,
   input  logic        subtract,
   output logic [31:0] result,
   output logic        carry
);

   logic [32:0] sum;

   always_comb begin
      if (subtract) begin
         sum = {1'b0, acc} - {1'b0, operand};
      end else begin
         sum = {1'b0, acc} + {1'b0, operand};
      end
   end

   assign result = sum[31:0];
   assign carry  = sum[32];

endmodule

// File: rtl/ecc_seq.sv
// ----------------------------------------------------------------------------
// Conversion sequencer
// Steps the shared adder through the year, month, day, hour and minute loops
// in either direction and assembles the result word.
// ----------------------------------------------------------------------------
module ecc_seq (
   input  logic                clock,
   input  logic                reset,
   ecc_req_if.sink             req_chan,
   input  ecc_pkg::cfg_type    cfg,
   output logic                done,
   output ecc_pkg::result_type result,
   input  logic                take
);

   ecc_pkg::state_type state_ff, state_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [31:0] acc_ff, acc_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [2:0]  step_ff, step_in;
   logic [5:0]  quot_ff, quot_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic        fail_ff, fail_in;
   logic [16:0] off_ff, off_in;
   logic        off_neg_ff, off_neg_in;
   logic [11:0] in_year_ff, in_year_in;
   logic [3:0]  in_month_ff, in_month_in;
   logic [4:0]  in_day_ff, in_day_in;
   logic [4:0]  in_hour_ff, in_hour_in;
   logic [5:0]  in_minute_ff, in_minute_in;
   logic [5:0]  in_second_ff, in_second_in;

   logic [31:0]        operand;
   logic               subtract;
   logic [31:0]        alu_result;
   logic               carry;
   logic [5:0]         quot_next;
   logic [4:0]         day_index;
   logic               cal_ok;
   logic signed [17:0] tz_ext;
   logic signed [17:0] local_secs;
   logic [17:0]        local_mag;

   ecc_alu u_alu (
      .acc      (acc_ff),
      .operand  (operand),
      .subtract (subtract),
      .result   (alu_result),
      .carry    (carry)
   );

   assign req_chan.ready = (state_ff == ecc_pkg::ST_IDLE);
   assign done           = (state_ff == ecc_pkg::ST_DONE);
   assign day_index      = in_day_ff - 5'd1;

   always_comb begin
      tz_ext     = 18'(cfg.tz_offset_minutes);
      local_secs = (tz_ext <<< 6) - (tz_ext <<< 2)
                   + (cfg.daylight_saving ? ecc_pkg::DST_SECS : 18'sd0);
      local_mag  = local_secs[17] ? 18'(-local_secs) : 18'(local_secs);
   end

   always_comb begin
      cal_ok = (in_year_ff >= ecc_pkg::YEAR_FIRST) && (in_year_ff <= ecc_pkg::YEAR_LAST)
               && (in_month_ff >= 4'd1) && (in_month_ff <= 4'd12)
               && (in_day_ff >= 5'd1)
               && (in_day_ff <= ecc_pkg::month_days(in_year_ff, in_month_ff))
               && (in_hour_ff <= 5'd23) && (in_minute_ff <= 6'd59)
               && (in_second_ff <= 6'd59);
   end

   always_comb begin
      operand  = 32'd0;
      subtract = 1'b0;
      unique case (state_ff)
         ecc_pkg::ST_OFFSET: begin
            operand  = {15'd0, off_ff};
            subtract = off_neg_ff;
         end
         ecc_pkg::ST_YEAR: begin
            operand  = ecc_pkg::year_secs(year_ff);
            subtract = 1'b1;
         end
         ecc_pkg::ST_MONTH: begin
            operand  = ecc_pkg::month_secs(year_ff, month_ff);
            subtract = 1'b1;
         end
         ecc_pkg::ST_DAY: begin
            operand  = ecc_pkg::SECS_DAY << step_ff;
            subtract = 1'b1;
         end
         ecc_pkg::ST_HOUR: begin
            operand  = ecc_pkg::SECS_HOUR << step_ff;
            subtract = 1'b1;
         end
         ecc_pkg::ST_MINUTE: begin
            operand  = ecc_pkg::SECS_MINUTE << step_ff;
            subtract = 1'b1;
         end
         ecc_pkg::ST_ADD_YEAR:   operand = ecc_pkg::year_secs(year_ff);
         ecc_pkg::ST_ADD_MONTH:  operand = ecc_pkg::month_secs(in_year_ff, month_ff);
         ecc_pkg::ST_ADD_DAY:    operand = ecc_pkg::SECS_DAY << step_ff;
         ecc_pkg::ST_ADD_HOUR:   operand = ecc_pkg::SECS_HOUR << step_ff;
         ecc_pkg::ST_ADD_MINUTE: operand = ecc_pkg::SECS_MINUTE << step_ff;
         ecc_pkg::ST_ADD_SECOND: operand = {26'd0, in_second_ff};
         ecc_pkg::ST_SUB_RTC: begin
            operand  = {15'd0, cfg.rtc_offset_seconds};
            subtract = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      quot_next = quot_ff;
      if (!carry) begin
         quot_next[step_ff] = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      acc_in       = acc_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      step_in      = step_ff;
      quot_in      = quot_ff;
      day_in       = day_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      fail_in      = fail_ff;
      off_in       = off_ff;
      off_neg_in   = off_neg_ff;
      in_year_in   = in_year_ff;
      in_month_in  = in_month_ff;
      in_day_in    = in_day_ff;
      in_hour_in   = in_hour_ff;
      in_minute_in = in_minute_ff;
      in_second_in = in_second_ff;

      unique case (state_ff)
         ecc_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in       = req_chan.cmd;
               acc_in       = req_chan.epoch_in;
               in_year_in   = req_chan.year;
               in_month_in  = req_chan.month;
               in_day_in    = req_chan.day;
               in_hour_in   = req_chan.hour;
               in_minute_in = req_chan.minute;
               in_second_in = req_chan.second;
               fail_in      = 1'b0;
               state_in     = ecc_pkg::ST_PREP;
            end
         end
         ecc_pkg::ST_PREP: begin
            year_in = ecc_pkg::YEAR_FIRST;
            unique case (cmd_ff) inside
               ecc_pkg::CMD_TO_UTC: begin
                  state_in = ecc_pkg::ST_YEAR;
               end
               ecc_pkg::CMD_TO_LOCAL: begin
                  off_in     = local_mag[16:0];
                  off_neg_in = local_secs[17];
                  state_in   = ecc_pkg::ST_OFFSET;
               end
               ecc_pkg::CMD_TO_RTC: begin
                  off_in     = cfg.rtc_offset_seconds;
                  off_neg_in = 1'b0;
                  state_in   = ecc_pkg::ST_OFFSET;
               end
               ecc_pkg::CMD_TO_SECS, ecc_pkg::CMD_RTC_TO_SECS: begin
                  acc_in = 32'd0;
                  if (cal_ok) begin
                     state_in = ecc_pkg::ST_ADD_YEAR;
                  end else begin
                     fail_in  = 1'b1;
                     state_in = ecc_pkg::ST_DONE;
                  end
               end
               default: begin
                  fail_in  = 1'b1;
                  state_in = ecc_pkg::ST_DONE;
               end
            endcase
         end
         ecc_pkg::ST_OFFSET: begin
            if (carry) begin
               fail_in  = 1'b1;
               state_in = ecc_pkg::ST_DONE;
            end else begin
               acc_in   = alu_result;
               state_in = ecc_pkg::ST_YEAR;
            end
         end
         ecc_pkg::ST_YEAR: begin
            if (!carry) begin
               acc_in  = alu_result;
               year_in = year_ff + 12'd1;
            end else begin
               month_in = 4'd1;
               state_in = ecc_pkg::ST_MONTH;
            end
         end
         ecc_pkg::ST_MONTH: begin
            if (month_ff != 4'd12 && !carry) begin
               acc_in   = alu_result;
               month_in = month_ff + 4'd1;
            end else begin
               step_in  = 3'd4;
               quot_in  = 6'd0;
               state_in = ecc_pkg::ST_DAY;
            end
         end
         ecc_pkg::ST_DAY: begin
            if (!carry) begin
               acc_in = alu_result;
            end
            quot_in = quot_next;
            if (step_ff == 3'd0) begin
               day_in   = quot_next[4:0] + 5'd1;
               quot_in  = 6'd0;
               step_in  = 3'd4;
               state_in = ecc_pkg::ST_HOUR;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         ecc_pkg::ST_HOUR: begin
            if (!carry) begin
               acc_in = alu_result;
            end
            quot_in = quot_next;
            if (step_ff == 3'd0) begin
               hour_in  = quot_next[4:0];
               quot_in  = 6'd0;
               step_in  = 3'd5;
               state_in = ecc_pkg::ST_MINUTE;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         ecc_pkg::ST_MINUTE: begin
            if (!carry) begin
               acc_in = alu_result;
            end
            quot_in = quot_next;
            if (step_ff == 3'd0) begin
               minute_in = quot_next;
               state_in  = ecc_pkg::ST_DONE;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         ecc_pkg::ST_ADD_YEAR: begin
            if (year_ff != in_year_ff) begin
               acc_in  = alu_result;
               year_in = year_ff + 12'd1;
            end else begin
               month_in = 4'd1;
               state_in = ecc_pkg::ST_ADD_MONTH;
            end
         end
         ecc_pkg::ST_ADD_MONTH: begin
            if (month_ff != in_month_ff) begin
               acc_in   = alu_result;
               month_in = month_ff + 4'd1;
            end else begin
               step_in  = 3'd4;
               state_in = ecc_pkg::ST_ADD_DAY;
            end
         end
         ecc_pkg::ST_ADD_DAY: begin
            if (day_index[step_ff]) begin
               acc_in = alu_result;
            end
            if (step_ff == 3'd0) begin
               step_in  = 3'd4;
               state_in = ecc_pkg::ST_ADD_HOUR;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         ecc_pkg::ST_ADD_HOUR: begin
            if (in_hour_ff[step_ff]) begin
               acc_in = alu_result;
            end
            if (step_ff == 3'd0) begin
               step_in  = 3'd5;
               state_in = ecc_pkg::ST_ADD_MINUTE;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         ecc_pkg::ST_ADD_MINUTE: begin
            if (in_minute_ff[step_ff]) begin
               acc_in = alu_result;
            end
            if (step_ff == 3'd0) begin
               state_in = ecc_pkg::ST_ADD_SECOND;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         ecc_pkg::ST_ADD_SECOND: begin
            acc_in = alu_result;
            if (cmd_ff == ecc_pkg::CMD_RTC_TO_SECS) begin
               state_in = ecc_pkg::ST_SUB_RTC;
            end else begin
               state_in = ecc_pkg::ST_DONE;
            end
         end
         ecc_pkg::ST_SUB_RTC: begin
            if (carry) begin
               fail_in = 1'b1;
            end else begin
               acc_in = alu_result;
            end
            state_in = ecc_pkg::ST_DONE;
         end
         ecc_pkg::ST_DONE: begin
            if (take) begin
               state_in = ecc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ecc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      result = '0;
      if (fail_ff) begin
         result.status = 1'b1;
      end else if (cmd_ff < ecc_pkg::CMD_TO_SECS) begin
         result.out_year   = year_ff;
         result.out_month  = month_ff;
         result.out_day    = day_ff;
         result.out_hour   = hour_ff;
         result.out_minute = minute_ff;
         result.out_second = acc_ff[5:0];
      end else begin
         result.epoch_out = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecc_pkg::ST_IDLE;
         fail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fail_ff  <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      acc_ff       <= acc_in;
      year_ff      <= year_in;
      month_ff     <= month_in;
      step_ff      <= step_in;
      quot_ff      <= quot_in;
      day_ff       <= day_in;
      hour_ff      <= hour_in;
      minute_ff    <= minute_in;
      off_ff       <= off_in;
      off_neg_ff   <= off_neg_in;
      in_year_ff   <= in_year_in;
      in_month_ff  <= in_month_in;
      in_day_ff    <= in_day_in;
      in_hour_ff   <= in_hour_in;
      in_minute_ff <= in_minute_in;
      in_second_ff <= in_second_in;
   end

endmodule

// File: rtl/epoch_calendar_converter_top.sv
// ----------------------------------------------------------------------------
// Epoch calendar converter
// Converts between Unix seconds and Gregorian calendar fields with local and
// hardware clock offsets.
//
//   Channel    Direction  Carries
//   req_chan   in         command, Unix seconds, calendar fields
//   rsp_chan   out        status, Unix seconds, calendar fields
//   csr_chan   in         register index, write data
//
// A request rejected at once finishes early; the longest ones are set by the
// year loop, which steps the shared adder once per year from 1970.
// The block takes one request at a time; a result waiting in the output
// register does not stop the next request from being taken.
// Synchronous reset restores the register defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module epoch_calendar_converter_top (
   input  logic      clock,
   input  logic      reset,
   ecc_req_if.sink   req_chan,
   ecc_rsp_if.source rsp_chan,
   ecc_csr_if.sink   csr_chan
);

   ecc_pkg::cfg_type    cfg;
   ecc_pkg::result_type eng_result;
   ecc_pkg::result_type result_ff, result_in;
   logic                eng_done;
   logic                take;
   logic                rsp_valid_ff, rsp_valid_in;

   ecc_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ecc_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg),
      .done     (eng_done),
      .result   (eng_result),
      .take     (take)
   );

   assign take = eng_done && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         result_in    = eng_result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = result_ff.status;
   assign rsp_chan.epoch_out  = result_ff.epoch_out;
   assign rsp_chan.out_year   = result_ff.out_year;
   assign rsp_chan.out_month  = result_ff.out_month;
   assign rsp_chan.out_day    = result_ff.out_day;
   assign rsp_chan.out_hour   = result_ff.out_hour;
   assign rsp_chan.out_minute = result_ff.out_minute;
   assign rsp_chan.out_second = result_ff.out_second;

   // The sequencer is not ready in the cycle after it takes a word.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken again straight after a request");

   // A failed word carries nothing but its status.
   a_fail_clears_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status |->
         rsp_chan.epoch_out == 32'd0 && rsp_chan.out_year == 12'd0
         && rsp_chan.out_month == 4'd0 && rsp_chan.out_day == 5'd0)
      else $error("failed response word carries non-zero fields");

   // A successful calendar word has legal month, day, hour, minute and second.
   a_calendar_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.status && rsp_chan.out_year != 12'd0 |->
         rsp_chan.out_month >= 4'd1 && rsp_chan.out_month <= 4'd12
         && rsp_chan.out_day >= 5'd1 && rsp_chan.out_hour <= 5'd23
         && rsp_chan.out_minute <= 6'd59 && rsp_chan.out_second <= 6'd59)
      else $error("calendar response word out of range");

endmodule
